### rtl/ove_pkg.sv
// Package for the organ voice envelope block: types, constants and helpers.
// No dependencies; every other file of the block but ove_ram imports it.
package ove_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DUR_W   = 28;
  localparam int unsigned LVL_W   = 16;
  localparam int unsigned RAT_W   = 17;
  localparam int unsigned RECIPS  = 6;
  localparam int unsigned CFG_W   = 28;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned VOICE_W = 5;

  localparam logic [RAT_W-1:0] ONE_Q16   = 17'h10000;
  localparam logic [17:0]      ENV_FLOOR = 18'd99;

  typedef enum logic [CIDX_W-1:0] {
    REG_ATTACK, REG_DECAY, REG_SUSTAIN, REG_RELEASE,
    REG_PATTACK, REG_PDECAY, REG_PRELEASE, REG_STEP
  } reg_idx_t;

  typedef enum logic [2:0] {
    RCP_ATTACK, RCP_DECAY, RCP_RELEASE, RCP_PATTACK, RCP_PDECAY, RCP_PRELEASE
  } rcp_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL_O, ST_MUL_P, ST_LVL_O, ST_LVL_P, ST_WB
  } state_t;

  typedef struct packed {
    logic [DUR_W-1:0] attack;
    logic [DUR_W-1:0] decay;
    logic [LVL_W-1:0] sustain;
    logic [DUR_W-1:0] release_t;
    logic [DUR_W-1:0] pattack;
    logic [DUR_W-1:0] pdecay;
    logic [DUR_W-1:0] prelease;
    logic [LVL_W-1:0] step;
  } cfg_t;

  typedef logic [RECIPS-1:0][31:0] recip_arr_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic mul_o;
    logic mul_p;
    logic lvl_o;
    logic lvl_p;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic cfg_busy;
    logic out_free;
  } stat_t;

  function automatic logic [LVL_W-1:0] sat16(input logic [17:0] v);
    return (v > 18'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

### rtl/ove_if.sv
// Stream interfaces for the input and result channels of the envelope block.
// Depends on ove_pkg for field widths.
interface ove_in_if import ove_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [VOICE_W-1:0] voice;
  logic               gate;
  logic               pedal;
  modport source (output valid, mode, voice, gate, pedal, input ready);
  modport sink (input valid, mode, voice, gate, pedal, output ready);
endinterface

interface ove_out_if import ove_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VOICE_W-1:0] voice_out;
  logic [LVL_W-1:0]   organ_env;
  logic [LVL_W-1:0]   perc_env;
  logic               active;
  modport source (output valid, voice_out, organ_env, perc_env, active, input ready);
  modport sink (input valid, voice_out, organ_env, perc_env, active, output ready);
endinterface

### rtl/organ_voice_envelope.sv
// Top level of the per-voice organ and percussion envelope generator.
// Depends on ove_pkg, ove_if, ove_cfg, ove_ctrl and ove_dp (with ove_ram).
//
//  channel  direction  handshake            payload
//  in_ch    sink       valid / ready        mode, voice, gate, pedal
//  out_ch   source     valid / ready        voice_out, organ_env, perc_env, active
//  cfg_*    sink       cfg_we               cfg_index, cfg_wdata
//
// A transaction passes through the read, ratio, level and write-back states after it is
// accepted, and the next one is accepted only after its write-back. This order is set
// by the two ratio products sharing one product register, followed by the two level products.
// After reset and after every configuration write the divider forms the six
// reciprocals in turn; no transaction is accepted then.
// A result waiting at the output holds the following transaction at write-back,
// and no input is accepted until that write-back is done.
module organ_voice_envelope import ove_pkg::*; #(
  parameter int unsigned VOICES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  ove_in_if.sink            in_ch,
  ove_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata
);
  cfg_t       cfg;
  recip_arr_t recip;
  logic       recip_busy;
  logic       dp_out_free;
  cmd_t       cmd;
  stat_t      stat;

  ove_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .cfg(cfg), .recip(recip), .busy(recip_busy)
  );

  assign stat = '{cfg_busy: recip_busy || cfg_we, out_free: dp_out_free};

  ove_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  ove_dp #(.VOICES(VOICES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_mode(in_ch.mode), .in_voice(in_ch.voice), .in_gate(in_ch.gate),
    .in_pedal(in_ch.pedal), .cfg(cfg), .recip(recip), .out_free(dp_out_free),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_voice(out_ch.voice_out),
    .out_organ(out_ch.organ_env), .out_perc(out_ch.perc_env), .out_active(out_ch.active)
  );

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !recip_busy)
    else $error("Transaction accepted while reciprocals were being formed.");
  a_wb_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |=> out_ch.valid)
    else $error("Write-back did not present a result.");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !in_ch.ready)
    else $error("Input ready while a transaction was in progress.");
`endif
endmodule

### rtl/ove_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ove_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/ove_cfg.sv
// Configuration registers and the restoring divider that forms the six reciprocals.
// Depends on ove_pkg.
module ove_cfg import ove_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output cfg_t              cfg,
  output recip_arr_t        recip,
  output logic              busy
);
  cfg_t        cfg_r;
  recip_arr_t  recip_r;
  logic        busy_r;
  logic [2:0]  idx_r;
  logic [5:0]  step_r;
  logic [DUR_W-1:0] rem_r, rem_nxt;
  logic [43:0] quo_r;
  logic [DUR_W-1:0] dsr_raw, dsr;
  logic [DUR_W:0]   shifted;
  logic             ge;
  logic [44:0]      q_full;

  always_comb begin
    unique case (rcp_idx_t'(idx_r))
      RCP_ATTACK:   dsr_raw = cfg_r.attack;
      RCP_DECAY:    dsr_raw = cfg_r.decay;
      RCP_RELEASE:  dsr_raw = cfg_r.release_t;
      RCP_PATTACK:  dsr_raw = cfg_r.pattack;
      RCP_PDECAY:   dsr_raw = cfg_r.pdecay;
      RCP_PRELEASE: dsr_raw = cfg_r.prelease;
      default:      dsr_raw = cfg_r.prelease;
    endcase
    dsr     = (dsr_raw == '0) ? DUR_W'(1) : dsr_raw;
    shifted = {rem_r, (step_r == 6'd0)};
    ge      = shifted >= {1'b0, dsr};
    rem_nxt = ge ? DUR_W'(shifted - {1'b0, dsr}) : shifted[DUR_W-1:0];
    q_full  = {quo_r, ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack    <= 28'd1677721;
      cfg_r.decay     <= 28'd3355443;
      cfg_r.sustain   <= 16'd52428;
      cfg_r.release_t <= 28'd10066329;
      cfg_r.pattack   <= 28'd167772;
      cfg_r.pdecay    <= 28'd3355443;
      cfg_r.prelease  <= 28'd3355443;
      cfg_r.step      <= 16'd175;
      busy_r <= 1'b1;
      idx_r  <= '0;
      step_r <= '0;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ATTACK:   cfg_r.attack    <= cfg_wdata;
        REG_DECAY:    cfg_r.decay     <= cfg_wdata;
        REG_SUSTAIN:  cfg_r.sustain   <= cfg_wdata[LVL_W-1:0];
        REG_RELEASE:  cfg_r.release_t <= cfg_wdata;
        REG_PATTACK:  cfg_r.pattack   <= cfg_wdata;
        REG_PDECAY:   cfg_r.pdecay    <= cfg_wdata;
        REG_PRELEASE: cfg_r.prelease  <= cfg_wdata;
        REG_STEP:     cfg_r.step      <= cfg_wdata[LVL_W-1:0];
        default:      cfg_r.step      <= cfg_wdata[LVL_W-1:0];
      endcase
      busy_r <= 1'b1;
      idx_r  <= '0;
      step_r <= '0;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      if (step_r == 6'd44) begin
        recip_r[idx_r] <= (q_full[44:32] != '0) ? 32'hFFFF_FFFF : q_full[31:0];
        step_r <= '0;
        rem_r  <= '0;
        quo_r  <= '0;
        if (idx_r == 3'(RECIPS - 1)) begin
          busy_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end else begin
        step_r <= step_r + 6'd1;
        rem_r  <= rem_nxt;
        quo_r  <= q_full[43:0];
      end
    end
  end

  assign cfg   = cfg_r;
  assign recip = recip_r;
  assign busy  = busy_r;
endmodule

### rtl/ove_ctrl.sv
// Controller state machine sequencing one transaction through the datapath.
// Depends on ove_pkg.
module ove_ctrl import ove_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_valid && !stat.cfg_busy) st_nxt = ST_READ;
      ST_READ:  st_nxt = ST_MUL_O;
      ST_MUL_O: st_nxt = ST_MUL_P;
      ST_MUL_P: st_nxt = ST_LVL_O;
      ST_LVL_O: st_nxt = ST_LVL_P;
      ST_LVL_P: st_nxt = ST_WB;
      ST_WB:    if (stat.out_free) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (st_r == ST_IDLE) && !stat.cfg_busy;
    cmd         = '0;
    cmd.capture = in_ready && in_valid;
    cmd.load    = (st_r == ST_READ);
    cmd.mul_o   = (st_r == ST_MUL_O);
    cmd.mul_p   = (st_r == ST_MUL_P);
    cmd.lvl_o   = (st_r == ST_LVL_O);
    cmd.lvl_p   = (st_r == ST_LVL_P);
    cmd.wb      = (st_r == ST_WB) && stat.out_free;
  end
endmodule

### rtl/ove_dp.sv
// Datapath: voice state RAM, active flags, ratio and level multipliers, result register.
// Depends on ove_pkg and ove_ram.
module ove_dp import ove_pkg::*; #(
  parameter int unsigned VOICES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic               in_mode,
  input  logic [VOICE_W-1:0] in_voice,
  input  logic               in_gate,
  input  logic               in_pedal,
  input  cfg_t               cfg,
  input  recip_arr_t         recip,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [VOICE_W-1:0] out_voice,
  output logic [LVL_W-1:0]   out_organ,
  output logic [LVL_W-1:0]   out_perc,
  output logic               out_active
);
  localparam int unsigned AW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned MW = TIME_W + 2 * LVL_W;

  logic               mode_r, gate_r, pedal_r, range_r;
  logic [VOICE_W-1:0] voice_r;
  logic [AW-1:0]      idx, idx_r;
  logic [VOICES-1:0]  von_r;
  logic [TIME_W-1:0]  t_r;
  logic [LVL_W-1:0]   ol_r, pl_r;
  logic [63:0]        prod_r;
  logic [RAT_W-1:0]   rat_o_r, rat_p_r, rat_c;
  logic [17:0]        lvl_o_r, lvl_p_r;
  logic               ov_r;
  logic [VOICE_W-1:0] ovoice_r;
  logic [LVL_W-1:0]   oorg_r, oprc_r;
  logic               oact_r;
  logic [MW-1:0]      rdata, wdata;
  logic               we;

  logic [28:0]        ad, pad;
  logic               gt_ad, gt_a, gt_pad, gt_pa, gp, rel_gt, kill, tick, note;
  logic [TIME_W-1:0]  xo, xp, ro, rp, tnew, tsat;
  logic [32:0]        tsum;
  logic [RAT_W-1:0]   ao, bo, bp;
  logic [LVL_W-1:0]   org, prc;

  assign idx = AW'(6'(in_voice));

  ove_ram #(.WIDTH(MW), .DEPTH(VOICES)) u_ram (
    .clk(clk), .we(we), .waddr(idx_r), .wdata(wdata),
    .re(cmd.capture), .raddr(idx), .rdata(rdata)
  );

  always_comb begin
    ad     = 29'(cfg.attack) + 29'(cfg.decay);
    pad    = 29'(cfg.pattack) + 29'(cfg.pdecay);
    gt_ad  = t_r > 32'(ad);
    gt_a   = t_r > 32'(cfg.attack);
    gt_pad = t_r > 32'(pad);
    gt_pa  = t_r > 32'(cfg.pattack);
    rel_gt = 32'(cfg.release_t) > t_r;
    gp     = gate_r || pedal_r;
    xo = (gate_r && gt_a) ? t_r - 32'(cfg.attack) : t_r;
    ro = gate_r ? (gt_a ? recip[RCP_DECAY] : recip[RCP_ATTACK]) : recip[RCP_RELEASE];
    xp = (gp && gt_pa) ? t_r - 32'(cfg.pattack) : t_r;
    rp = gp ? (gt_pa ? recip[RCP_PDECAY] : recip[RCP_PATTACK]) : recip[RCP_PRELEASE];
    rat_c = (prod_r[63:28] > 36'(ONE_Q16)) ? ONE_Q16 : prod_r[44:28];
    ao = gate_r ? ONE_Q16 - {1'b0, cfg.sustain} : {1'b0, ol_r};
    bo = gate_r ? rat_o_r : ONE_Q16 - rat_o_r;
    bp = ONE_Q16 - rat_p_r;

    kill = !gate_r && !pedal_r && (!rel_gt || (lvl_o_r < ENV_FLOOR));
    if (gate_r) begin
      if (gt_ad)     org = cfg.sustain;
      else if (gt_a) org = sat16(18'h10000 - lvl_o_r);
      else           org = sat16({1'b0, rat_o_r});
    end else if (pedal_r) begin
      org = cfg.sustain;
    end else begin
      org = kill ? '0 : sat16(lvl_o_r);
    end
    if (gp) begin
      if (gt_pad)     prc = '0;
      else if (gt_pa) prc = sat16({1'b0, ONE_Q16 - rat_p_r});
      else            prc = sat16({1'b0, rat_p_r});
    end else begin
      prc = sat16(lvl_p_r);
    end

    tick = !mode_r && range_r && von_r[idx_r];
    note = mode_r && range_r;
    tnew = kill ? '0 : t_r;
    tsum = 33'(tnew) + 33'(cfg.step);
    tsat = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
    we    = cmd.wb && (tick || note);
    wdata = note ? '0 : {tsat, org, prc};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      gate_r  <= in_gate;
      pedal_r <= in_pedal;
      voice_r <= in_voice;
      idx_r   <= idx;
      range_r <= 7'(in_voice) < 7'(VOICES);
    end
    if (cmd.load) begin
      t_r  <= rdata[MW-1:2*LVL_W];
      ol_r <= rdata[2*LVL_W-1:LVL_W];
      pl_r <= rdata[LVL_W-1:0];
    end
    if (cmd.mul_o) prod_r <= 64'(xo) * 64'(ro);
    if (cmd.mul_p) begin
      prod_r  <= 64'(xp) * 64'(rp);
      rat_o_r <= rat_c;
    end
    if (cmd.lvl_o) begin
      lvl_o_r <= 18'((34'(ao) * 34'(bo)) >> 16);
      rat_p_r <= rat_c;
    end
    if (cmd.lvl_p) lvl_p_r <= 18'((34'({1'b0, pl_r}) * 34'(bp)) >> 16);
    if (cmd.wb) begin
      ovoice_r <= voice_r;
      oorg_r   <= tick ? org : '0;
      oprc_r   <= tick ? prc : '0;
      oact_r   <= note || (tick && !kill);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      von_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (cmd.wb && note) von_r[idx_r] <= 1'b1;
      else if (cmd.wb && tick && kill) von_r[idx_r] <= 1'b0;
      if (cmd.wb) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  assign out_free   = !ov_r || out_ready;
  assign out_valid  = ov_r;
  assign out_voice  = ovoice_r;
  assign out_organ  = oorg_r;
  assign out_perc   = oprc_r;
  assign out_active = oact_r;
endmodule

### test/tb_organ_voice_envelope.sv
// Testbench for organ_voice_envelope: random and directed ticks and note starts,
// checked against a per-voice envelope predictor held in a scoreboard class.
// Depends on ove_pkg, the ove_in_if / ove_out_if interfaces and the block's RTL.
`timescale 1ns / 100ps

module tb_organ_voice_envelope;
  import ove_pkg::*;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;
  localparam int unsigned NVOICE = 32;
  localparam logic [63:0] LEVEL_FLOOR = 64'd99;
  localparam logic [27:0] DUR_MAX = 28'hFFFFFFF;

  typedef struct packed {
    logic [4:0]  voice;
    logic [15:0] organ;
    logic [15:0] perc;
    logic        active;
  } env_result_t;

  class EnvScoreboard;
    logic [27:0] regs [8];
    logic [31:0] rcp [6];
    logic [31:0] vtime [NVOICE];
    logic [15:0] olvl [NVOICE];
    logic [15:0] plvl [NVOICE];
    bit          von [NVOICE];
    env_result_t expected_q[$];
    int          errors;

    function new();
      regs[REG_ATTACK]   = 28'd1677721;
      regs[REG_DECAY]    = 28'd3355443;
      regs[REG_SUSTAIN]  = 28'd52428;
      regs[REG_RELEASE]  = 28'd10066329;
      regs[REG_PATTACK]  = 28'd167772;
      regs[REG_PDECAY]   = 28'd3355443;
      regs[REG_PRELEASE] = 28'd3355443;
      regs[REG_STEP]     = 28'd175;
      for (int i = 0; i < NVOICE; i++) begin
        vtime[i] = 0; olvl[i] = 0; plvl[i] = 0; von[i] = 0;
      end
      errors = 0;
      refresh_rates();
    endfunction

    function logic [31:0] recip(logic [27:0] t);
      logic [63:0] d, r;
      d = (t == 0) ? 64'd1 : {36'd0, t};
      r = (64'd1 << 44) / d;
      return (r > 64'hFFFFFFFF) ? 32'hFFFFFFFF : r[31:0];
    endfunction

    function void refresh_rates();
      rcp[RCP_ATTACK]   = recip(regs[REG_ATTACK]);
      rcp[RCP_DECAY]    = recip(regs[REG_DECAY]);
      rcp[RCP_RELEASE]  = recip(regs[REG_RELEASE]);
      rcp[RCP_PATTACK]  = recip(regs[REG_PATTACK]);
      rcp[RCP_PDECAY]   = recip(regs[REG_PDECAY]);
      rcp[RCP_PRELEASE] = recip(regs[REG_PRELEASE]);
    endfunction

    function void write_reg(reg_idx_t idx, logic [27:0] val);
      if (idx == REG_SUSTAIN || idx == REG_STEP) val[27:16] = '0;
      regs[idx] = val;
      refresh_rates();
    endfunction

    function logic [63:0] ratio(logic [63:0] x, logic [31:0] r);
      logic [63:0] p;
      p = (x * {32'd0, r}) >> 28;
      return (p > 64'd65536) ? 64'd65536 : p;
    endfunction

    function logic [15:0] clip16(logic [63:0] v);
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function void note_input(logic mode, logic [4:0] v, logic gate, logic pedal);
      env_result_t res;
      logic [63:0] t, a, d, s, rel, pa, pd, e, sum;
      logic [31:0] tnew;
      bit kill;
      res = '0;
      res.voice = v;
      if (mode == MODE_START) begin
        vtime[v] = 0; olvl[v] = 0; plvl[v] = 0; von[v] = 1;
        res.active = 1'b1;
      end else if (von[v]) begin
        t = vtime[v];
        a = regs[REG_ATTACK]; d = regs[REG_DECAY]; s = regs[REG_SUSTAIN];
        rel = regs[REG_RELEASE]; pa = regs[REG_PATTACK]; pd = regs[REG_PDECAY];
        tnew = vtime[v];
        if (gate) begin
          if (t > a + d) res.organ = s[15:0];
          else if (t > a)
            res.organ = clip16(64'd65536 -
                        (((64'd65536 - s) * ratio(t - a, rcp[RCP_DECAY])) >> 16));
          else res.organ = clip16(ratio(t, rcp[RCP_ATTACK]));
        end else if (pedal) begin
          res.organ = s[15:0];
        end else begin
          kill = 1;
          if (rel > t) begin
            e = ({48'd0, olvl[v]} * (64'd65536 - ratio(t, rcp[RCP_RELEASE]))) >> 16;
            if (e >= LEVEL_FLOOR) begin
              res.organ = clip16(e);
              kill = 0;
            end
          end
          if (kill) begin
            res.organ = 0; von[v] = 0; tnew = 0;
          end
        end
        if (gate || pedal) begin
          if (t > pa + pd) res.perc = 0;
          else if (t > pa) res.perc = clip16(64'd65536 - ratio(t - pa, rcp[RCP_PDECAY]));
          else res.perc = clip16(ratio(t, rcp[RCP_PATTACK]));
        end else begin
          res.perc = clip16(({48'd0, plvl[v]} *
                     (64'd65536 - ratio(t, rcp[RCP_PRELEASE]))) >> 16);
        end
        olvl[v] = res.organ;
        plvl[v] = res.perc;
        sum = {32'd0, tnew} + {36'd0, regs[REG_STEP]};
        vtime[v] = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
        res.active = von[v];
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(env_result_t got);
      env_result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: voice %0d organ %0d perc %0d active %0d",
                 $time, got.voice, got.organ, got.perc, got.active);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.voice !== exp_r.voice) begin
        $display("%0t: voice_out expected %0d actual %0d", $time, exp_r.voice, got.voice);
        errors++;
      end
      if (got.organ !== exp_r.organ) begin
        $display("%0t: organ_env voice %0d expected %0d actual %0d",
                 $time, exp_r.voice, exp_r.organ, got.organ);
        errors++;
      end
      if (got.perc !== exp_r.perc) begin
        $display("%0t: perc_env voice %0d expected %0d actual %0d",
                 $time, exp_r.voice, exp_r.perc, got.perc);
        errors++;
      end
      if (got.active !== exp_r.active) begin
        $display("%0t: active voice %0d expected %0d actual %0d",
                 $time, exp_r.voice, exp_r.active, got.active);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  ove_in_if in_ch ();
  ove_out_if out_ch ();

  organ_voice_envelope dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  EnvScoreboard envelope_sb;
  bit gate_held [NVOICE];
  bit pedal_held;
  int sink_style;
  int sink_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // Receiver: a new stall pattern is picked each time sink_count wraps, from free-running,
  // random and periodic stalls.
  always @(negedge clk) begin
    if (sink_count == 0) sink_style = $urandom_range(0, 3);
    sink_count = (sink_count + 1) % 64;
    case (sink_style)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = 1'($urandom_range(0, 1));
      2: out_ch.ready = (sink_count % 8) < 5;
      default: out_ch.ready = ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      envelope_sb.check_result({out_ch.voice_out, out_ch.organ_env,
                                out_ch.perc_env, out_ch.active});
  end

  task automatic send_item(logic mode, logic [4:0] v, logic gate, logic pedal);
    in_ch.valid = 1'b1;
    in_ch.mode = mode;
    in_ch.voice = v;
    in_ch.gate = gate;
    in_ch.pedal = pedal;
    do @(posedge clk); while (!in_ch.ready);
    envelope_sb.note_input(mode, v, gate, pedal);
    @(negedge clk);
  endtask

  task automatic idle_input(int cycles);
    in_ch.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (envelope_sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [27:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    envelope_sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_settings(logic [27:0] a, logic [27:0] d, logic [27:0] s,
                               logic [27:0] r, logic [27:0] pa, logic [27:0] pd,
                               logic [27:0] pr, logic [27:0] st);
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_SUSTAIN, s);
    write_reg(REG_RELEASE, r);
    write_reg(REG_PATTACK, pa);
    write_reg(REG_PDECAY, pd);
    write_reg(REG_PRELEASE, pr);
    write_reg(REG_STEP, st);
  endtask

  function automatic logic [27:0] short_span();
    return 28'($urandom_range(1, 6000));
  endfunction

  task automatic random_phase(int items);
    logic [4:0] v;
    int sent;
    int burst;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < items; b++) begin
        v = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(0, 3));
        if ($urandom_range(0, 29) == 0) gate_held[v] = ~gate_held[v];
        if ($urandom_range(0, 59) == 0) pedal_held = ~pedal_held;
        if ($urandom_range(0, 19) == 0) begin
          gate_held[v] = 1'b1;
          send_item(MODE_START, v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if ($urandom_range(0, 15) == 0) begin
          send_item(MODE_TICK, v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          send_item(MODE_TICK, v, gate_held[v], pedal_held);
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 6));
    end
    drain();
  endtask

  initial begin
    envelope_sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.voice = '0;
    in_ch.gate = 1'b0;
    in_ch.pedal = 1'b0;
    out_ch.ready = 1'b0;
    sink_style = 0;
    sink_count = 0;
    pedal_held = 1'b0;
    for (int i = 0; i < NVOICE; i++) gate_held[i] = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: start, attack, pedal hold, release, inactive voice.
    send_item(MODE_TICK, 5'd31, 1'b1, 1'b1);
    send_item(MODE_START, 5'd0, 1'b0, 1'b0);
    send_item(MODE_TICK, 5'd0, 1'b1, 1'b0);
    send_item(MODE_TICK, 5'd0, 1'b1, 1'b0);
    send_item(MODE_TICK, 5'd0, 1'b0, 1'b1);
    send_item(MODE_TICK, 5'd0, 1'b0, 1'b0);
    send_item(MODE_TICK, 5'd0, 1'b0, 1'b0);
    send_item(MODE_START, 5'd31, 1'b1, 1'b1);
    send_item(MODE_TICK, 5'd31, 1'b1, 1'b1);
    drain();

    // Shortest durations, zero duration and the largest step: attack, sustain,
    // percussion past its end, and release past its end.
    load_settings(28'd1, 28'd0, 28'd65535, 28'd1, 28'd0, 28'd1, 28'd1, 28'd65535);
    send_item(MODE_START, 5'd21, 1'b0, 1'b0);
    send_item(MODE_TICK, 5'd21, 1'b1, 1'b0);
    send_item(MODE_TICK, 5'd21, 1'b1, 1'b0);
    send_item(MODE_TICK, 5'd21, 1'b0, 1'b1);
    send_item(MODE_TICK, 5'd21, 1'b0, 1'b0);
    send_item(MODE_TICK, 5'd21, 1'b0, 1'b0);
    drain();

    // Small spans with a mid-range sustain for attack and decay.
    load_settings(28'd400, 28'd600, 28'd30000, 28'd2000, 28'd200, 28'd500, 28'd900, 28'd100);
    send_item(MODE_START, 5'd10, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++) send_item(MODE_TICK, 5'd10, 1'b1, 1'b0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_settings(DUR_MAX, DUR_MAX, 28'd0, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX,
                         28'd65535);
        1: load_settings(28'd1, 28'd1, 28'd0, 28'd1, 28'd1, 28'd1, 28'd1, 28'd1);
        2: load_settings(short_span(), short_span(), 28'd65535, short_span(),
                         short_span(), short_span(), short_span(), 28'd1);
        default: load_settings(short_span(), short_span(), 28'($urandom_range(0, 65535)),
                               28'($urandom_range(1, 40000)), short_span(),
                               short_span(), short_span(), 28'($urandom_range(1, 400)));
      endcase
      random_phase(200);
    end

    if (envelope_sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
